// ===== design/l2rs_pkg.sv =====
// Shared types, constants and Lanczos2 weight tables for the line resampler.
// Used by l2rs_mac and lanczos2_line_resampler_core; no dependencies.
package l2rs_pkg;

    localparam int PIX_BITS         = 12;
    localparam int WEIGHT_FRAC_BITS = 14;
    localparam int WIN_TAPS         = 8;
    localparam int WIN_IDX_W        = $clog2(WIN_TAPS);
    localparam int POS_W            = 13;
    localparam int WGT_W            = 16;
    localparam int PROD_W           = WGT_W + PIX_BITS + 1;
    localparam int ACC_W            = PROD_W + 3;
    localparam int MODE_W           = 2;
    localparam int TDATA_W          = 16;

    localparam logic [POS_W-1:0] POS_TOP = {POS_W{1'b1}};

    typedef logic [PIX_BITS-1:0]              t_pix;
    typedef t_pix [WIN_TAPS-1:0]              t_win;
    typedef logic signed [WGT_W-1:0]          t_wgt;
    typedef logic [WIN_IDX_W-1:0]             t_widx;

    typedef enum logic [1:0] {
        OP_COPY = 2'd0,
        OP_UP   = 2'd1,
        OP_HALF = 2'd2
    } t_op;

    // Mode register codes.
    localparam logic [MODE_W-1:0] MODE_COPY = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HALF = 2'd2;

    typedef struct packed {
        logic valid;
        t_op  op;
        logic mark_last;
        t_pix copy_pix;
    } t_ctrl;

    // Upscale lanes: lanes 0..3 give the even phase (window taps 3..6),
    // lanes 4..7 give the odd phase (window taps 4..7).
    localparam t_wgt UP_W [WIN_TAPS] = '{
        -16'sd290, 16'sd3817, 16'sd14231, -16'sd1374,
        -16'sd1374, 16'sd14231, 16'sd3817, -16'sd290
    };
    localparam t_widx UP_IDX [WIN_TAPS] = '{
        3'd3, 3'd4, 3'd5, 3'd6, 3'd4, 3'd5, 3'd6, 3'd7
    };
    // Half-rate kernel over the whole window, sums to one half of 2^14 per side.
    localparam t_wgt HALF_W [WIN_TAPS] = '{
        -16'sd145, -16'sd687, 16'sd1909, 16'sd7115,
        16'sd7115, 16'sd1909, -16'sd687, -16'sd145
    };

    function automatic t_op mode_to_op(input logic [MODE_W-1:0] mode);
        t_op op;
        unique case (mode)
            MODE_UP:   op = OP_UP;
            MODE_HALF: op = OP_HALF;
            default:   op = OP_COPY;
        endcase
        return op;
    endfunction

endpackage

// ===== design/l2rs_mac.sv =====
// Two-stage filter datapath: eight weighted taps, then sums, rounding and clamping.
// Depends on l2rs_pkg for the window type, weight tables and control struct.
module l2rs_mac import l2rs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_win  i_win,
    input  t_ctrl i_ctrl,
    output t_ctrl o_ctrl,
    output t_pix  o_res0,
    output t_pix  o_res1
);

    localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(1) <<< (WEIGHT_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] TOP   = ACC_W'(1) <<< (WEIGHT_FRAC_BITS + PIX_BITS);

    logic signed [PROD_W-1:0] r_prod [WIN_TAPS];
    logic signed [PROD_W-1:0] n_prod [WIN_TAPS];
    t_ctrl                    r_ctrl_p;
    t_ctrl                    r_ctrl_s;
    t_pix                     r_res0;
    t_pix                     r_res1;
    logic signed [ACC_W-1:0]  w_lo;
    logic signed [ACC_W-1:0]  w_hi;
    logic signed [ACC_W-1:0]  w_acc0;

    // Rounded sum to pixel: negative or zero gives 0, overflow gives full scale.
    function automatic t_pix round_clamp(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] r;
        t_pix                    v;
        r = acc + ROUND;
        if (r <= 0) begin
            v = '0;
        end else if (r >= TOP) begin
            v = '1;
        end else begin
            v = r[WEIGHT_FRAC_BITS +: PIX_BITS];
        end
        return v;
    endfunction

    always_comb begin
        for (int i = 0; i < WIN_TAPS; i++) begin
            if (i_ctrl.op == OP_HALF) begin
                n_prod[i] = PROD_W'(HALF_W[i] * $signed({1'b0, i_win[i]}));
            end else begin
                n_prod[i] = PROD_W'(UP_W[i] * $signed({1'b0, i_win[UP_IDX[i]]}));
            end
        end
    end

    always_comb begin
        w_lo = ACC_W'(r_prod[0]) + ACC_W'(r_prod[1]) + ACC_W'(r_prod[2]) + ACC_W'(r_prod[3]);
        w_hi = ACC_W'(r_prod[4]) + ACC_W'(r_prod[5]) + ACC_W'(r_prod[6]) + ACC_W'(r_prod[7]);
        w_acc0 = (r_ctrl_p.op == OP_HALF) ? (w_lo + w_hi) : w_lo;
    end

    always_ff @(posedge i_clk) begin
        r_prod             <= n_prod;
        r_ctrl_p.op        <= i_ctrl.op;
        r_ctrl_p.mark_last <= i_ctrl.mark_last;
        r_ctrl_p.copy_pix  <= i_ctrl.copy_pix;
        r_ctrl_s.op        <= r_ctrl_p.op;
        r_ctrl_s.mark_last <= r_ctrl_p.mark_last;
        r_ctrl_s.copy_pix  <= r_ctrl_p.copy_pix;
        r_res0             <= round_clamp(w_acc0);
        r_res1             <= round_clamp(w_hi);
        if (!i_rst_n) begin
            r_ctrl_p.valid <= 1'b0;
            r_ctrl_s.valid <= 1'b0;
        end else begin
            r_ctrl_p.valid <= i_ctrl.valid;
            r_ctrl_s.valid <= r_ctrl_p.valid;
        end
    end

    assign o_ctrl = r_ctrl_s;
    assign o_res0 = r_res0;
    assign o_res1 = r_res1;

endmodule

// ===== design/lanczos2_line_resampler_core.sv =====
// Lanczos2 line resampler top level: window sequencer, result queue and ports.
// Depends on l2rs_pkg and instantiates l2rs_mac for the filter arithmetic.
//
// Usage: pixels of one line enter on the slave stream (tdata = pixel, tlast marks
// the final pixel of the line). Resampled pixels leave on the master stream with
// tlast set on the final output of each line. Reset selects upscale. The user must
// write the mode register on the configuration channel only while the block is idle;
// the block does not enforce it. Codes: 0 copies, 1 upscales by two, 2 downscales
// by half, 3 behaves as copy. The first pixel of a line fills the whole 8-tap window,
// and after the last pixel the block pushes that pixel again (two extra window steps
// in upscale, three or four in half mode) to produce the outputs that hang past the
// line edge; input ready is low during those steps.
// An input transaction goes through the window register, product register and sum
// register, then a queue write, before its first result. While the queue has room,
// the window advances once per cycle and copy and half mode take an item every cycle;
// upscale mode gives two results per window step, so with a receiver taking one
// transaction per cycle its input is held back by the single output port draining
// the 16-entry result queue.
// A stalled receiver fills the queue; each window step reserves its result slots
// up front, and input ready drops once fewer than two free slots remain, so no
// result is ever dropped and the block resumes at full rate when the stall ends.
module lanczos2_line_resampler_core import l2rs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration channel: scale_mode[1:0].
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [MODE_W-1:0]    i_cfg_data,
    // Input stream.
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [TDATA_W-1:0]   i_s_tdata,   // [11:0] pixel_in, [15:12] zero
    input  logic                 i_s_tlast,   // last_in_line
    // Output stream.
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [TDATA_W-1:0]   o_m_tdata,   // [11:0] pixel_out, [15:12] zero
    output logic                 o_m_tlast    // last_out
);

    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = FIFO_AW + 1;
    localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(FIFO_DEPTH - 2);

    // Mode register and line sequencer state.
    logic [MODE_W-1:0]  r_scale_mode;
    logic [POS_W-1:0]   r_pos;
    logic [2:0]         r_flush_cnt;
    t_op                r_run_op;
    t_pix               r_hold;
    t_win               r_win;
    t_ctrl              r_c1;

    // Result queue.
    t_pix               r_fifo_pix  [FIFO_DEPTH];
    logic               r_fifo_last [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   r_used;

    logic               w_flushing;
    logic               w_room;
    logic               w_step;
    t_pix               w_pix;
    t_op                w_op;
    logic               w_fill;
    logic               w_emit;
    logic               w_final;
    logic [2:0]         w_cnt_init;
    logic [POS_W-1:0]   w_next_pos;
    logic [CNT_W-1:0]   w_resv;
    logic               w_pop;
    t_ctrl              w_c3;
    t_pix               w_res0;
    t_pix               w_res1;
    logic [CNT_W-1:0]   w_wr_n;
    logic [FIFO_AW-1:0] w_wr1;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_mode <= MODE_UP;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_scale_mode <= i_cfg_data;
        end
    end

    // One window step per cycle when the queue has room: either an accepted pixel or
    // an edge replication after the last pixel of a line.
    always_comb begin
        w_flushing = (r_flush_cnt != '0);
        w_room     = (r_used <= ROOM_LIMIT);
        w_pix      = w_flushing ? r_hold : i_s_tdata[PIX_BITS-1:0];
        w_op       = w_flushing ? r_run_op : mode_to_op(r_scale_mode);
        w_fill     = !w_flushing && (r_pos == '0);
        w_step     = w_room && (w_flushing || i_s_tvalid);
        o_s_tready = w_room && !w_flushing;

        case (w_op)
            OP_UP: begin
                w_emit     = (r_pos >= POS_W'(2));
                w_cnt_init = 3'd2;
            end
            OP_HALF: begin
                w_emit     = (r_pos >= POS_W'(4)) && !r_pos[0];
                w_cnt_init = r_pos[0] ? 3'd3 : 3'd4;
            end
            default: begin
                w_emit     = 1'b1;
                w_cnt_init = 3'd0;
            end
        endcase

        // The closing step of a line always produces a result, which carries tlast.
        w_final    = w_flushing ? (r_flush_cnt == 3'd1) : (i_s_tlast && w_cnt_init == '0);
        w_next_pos = (r_pos == POS_TOP) ? POS_TOP - POS_W'(1) : r_pos + POS_W'(1);

        if (w_step && w_emit) begin
            w_resv = (w_op == OP_UP) ? CNT_W'(2) : CNT_W'(1);
        end else begin
            w_resv = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            if (w_fill) begin
                r_win <= {WIN_TAPS{w_pix}};
            end else begin
                r_win <= {w_pix, r_win[WIN_TAPS-1:1]};
            end
        end
        r_c1.op        <= w_op;
        r_c1.mark_last <= w_final;
        r_c1.copy_pix  <= w_pix;
        if (w_step && !w_flushing) begin
            r_hold <= w_pix;
        end

        if (!i_rst_n) begin
            r_pos       <= '0;
            r_flush_cnt <= '0;
            r_run_op    <= OP_UP;
            r_c1.valid  <= 1'b0;
        end else begin
            r_c1.valid <= w_step && w_emit;
            if (w_step) begin
                r_pos <= w_final ? '0 : w_next_pos;
                if (w_flushing) begin
                    r_flush_cnt <= r_flush_cnt - 3'd1;
                end else begin
                    r_run_op <= w_op;
                    if (i_s_tlast) begin
                        r_flush_cnt <= w_cnt_init;
                    end
                end
            end
        end
    end

    l2rs_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_win   (r_win),
        .i_ctrl  (r_c1),
        .o_ctrl  (w_c3),
        .o_res0  (w_res0),
        .o_res1  (w_res1)
    );

    // Result queue: one or two entries per finished step, one read per cycle on tready.
    always_comb begin
        w_pop = o_m_tvalid && i_m_tready;
        w_wr1 = r_wr + FIFO_AW'(1);
        if (w_c3.valid) begin
            w_wr_n = (w_c3.op == OP_UP) ? CNT_W'(2) : CNT_W'(1);
        end else begin
            w_wr_n = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_c3.valid) begin
            r_fifo_pix[r_wr]  <= (w_c3.op == OP_COPY) ? w_c3.copy_pix : w_res0;
            r_fifo_last[r_wr] <= w_c3.mark_last && (w_c3.op != OP_UP);
            if (w_c3.op == OP_UP) begin
                r_fifo_pix[w_wr1]  <= w_res1;
                r_fifo_last[w_wr1] <= w_c3.mark_last;
            end
        end

        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_cnt  <= '0;
            r_used <= '0;
        end else begin
            r_wr   <= r_wr + FIFO_AW'(w_wr_n);
            r_rd   <= r_rd + FIFO_AW'(w_pop);
            r_cnt  <= r_cnt + w_wr_n - CNT_W'(w_pop);
            r_used <= r_used + w_resv - CNT_W'(w_pop);
        end
    end

    assign o_m_tvalid = (r_cnt != '0);
    assign o_m_tdata  = TDATA_W'(r_fifo_pix[r_rd]);
    assign o_m_tlast  = r_fifo_last[r_rd];

`ifndef SYNTHESIS
    // Reservations never exceed the queue.
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(FIFO_DEPTH))
        else $error("result reservations exceed queue depth");

    // Stored results are always covered by reservations.
    a_cnt_covered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= r_used)
        else $error("queue holds results that were never reserved");

    // No new pixel is taken while the line end is being replicated.
    a_no_accept_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_flush_cnt != '0) |-> !o_s_tready)
        else $error("input ready during line-end flush");
`endif

endmodule
